FILE: sv/perlin_noise_turbulence_3d_defines.svh
// Assertion macros used by the back-end RTL file.
// The module that uses them provides clk and rst_n.
`ifndef PERLIN_NOISE_TURBULENCE_3D_DEFINES_SVH
`define PERLIN_NOISE_TURBULENCE_3D_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PNT3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PNT3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PNT3D_ASSERT_IMP(lbl, ante, cons, msg)
`define PNT3D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/pnt3d_pkg.sv
package pnt3d_pkg;

  // table geometry
  localparam int TABLE_SIZE = 128;
  localparam int TAW        = $clog2(TABLE_SIZE);
  localparam int FRAC_W     = 16;
  localparam int COORD_W    = TAW + FRAC_W;
  localparam int LAT_CELL   = 10000 % TABLE_SIZE;
  localparam logic [COORD_W-1:0] LAT_Q = COORD_W'(LAT_CELL) << FRAC_W;

  // datapath width for dot products and blends
  localparam int DW = 22;

  localparam int OCT_W = 5;
  localparam logic [OCT_W-1:0] MAX_OCT = OCT_W'(16);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_LF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 3'd4;

  typedef enum logic [1:0] {
    REQ_PERM = 2'd0,
    REQ_GRAD = 2'd1,
    REQ_EVAL = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
  } grad_t;

  typedef struct packed {
    req_t               kind;
    logic [TAW-1:0]     idx;
    logic [TAW-1:0]     pval;
    grad_t              grad;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } q_item_t;

  typedef struct packed {
    logic               eval_mode;
    logic [OCT_W-1:0]   octave_count;
    logic [31:0]        inv_low_freq;
    logic signed [31:0] x_offset;
    logic signed [31:0] turb_bias;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    eval_mode:    1'b1,
    octave_count: 5'd7,
    inv_low_freq: 32'd6553600,
    x_offset:     32'sd8090812,
    turb_bias:    -32'sd19661
  };

endpackage

FILE: sv/pnt3d_if.sv
// Request channel
interface pnt3d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [6:0]         table_index;
  logic [6:0]         perm_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, req_type, table_index, perm_value,
                  grad_x, grad_y, grad_z, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, req_type, table_index, perm_value,
                  grad_x, grad_y, grad_z, pos_x, pos_y, pos_z, output ready);
endinterface

// Result channel
interface pnt3d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink   (input valid, result_value, saturated, output ready);
endinterface

// Register write channel
interface pnt3d_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: sv/pnt3d_front.sv
module pnt3d_front (
  input  logic              clk,
  input  logic              rst_n,
  pnt3d_in_if.sink          in_ch,
  output pnt3d_pkg::q_item_t q_ent,
  output logic              q_valid,
  input  logic              q_pop
);
  import pnt3d_pkg::*;

  q_item_t    ent_r [2];
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic [1:0] cnt_r;
  logic       take;
  logic       push;
  q_item_t    item;

  // classify: type 3 is taken and dropped
  assign in_ch.ready = (cnt_r != 2'd2);
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = take && (req_t'(in_ch.req_type) != REQ_NONE);

  always_comb begin
    item.kind  = req_t'(in_ch.req_type);
    item.idx   = in_ch.table_index;
    item.pval  = in_ch.perm_value;
    item.grad  = '{gx: in_ch.grad_x, gy: in_ch.grad_y, gz: in_ch.grad_z};
    item.pos_x = in_ch.pos_x;
    item.pos_y = in_ch.pos_y;
    item.pos_z = in_ch.pos_z;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_ent   = ent_r[rd_ptr_r];

  // two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= item;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: sv/pnt3d_back.sv
`include "perlin_noise_turbulence_3d_defines.svh"

module pnt3d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pnt3d_pkg::cfg_t    cfg,
  input  pnt3d_pkg::q_item_t q_ent,
  input  logic               q_valid,
  output logic               q_pop,
  pnt3d_out_if.source        out_ch
);
  import pnt3d_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

  // sequencer steps of one octave
  localparam logic [4:0] S_TCALC = 5'd0;
  localparam logic [4:0] S_PX    = 5'd1;
  localparam logic [4:0] S_PY0   = 5'd2;
  localparam logic [4:0] S_PY1   = 5'd3;
  localparam logic [4:0] S_G0    = 5'd4;
  localparam logic [4:0] S_G1    = 5'd5;
  localparam logic [4:0] S_G2    = 5'd6;
  localparam logic [4:0] S_G3    = 5'd7;
  localparam logic [4:0] S_G4    = 5'd8;
  localparam logic [4:0] S_L0    = 5'd9;
  localparam logic [4:0] S_L1    = 5'd10;
  localparam logic [4:0] S_L2    = 5'd11;
  localparam logic [4:0] S_L3    = 5'd12;
  localparam logic [4:0] S_L4    = 5'd13;
  localparam logic [4:0] S_L5    = 5'd14;
  localparam logic [4:0] S_L6    = 5'd15;
  localparam logic [4:0] S_NZ    = 5'd16;
  localparam logic [4:0] S_MUL   = 5'd17;
  localparam logic [4:0] S_ACC   = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  localparam int SUM_W  = DW + 20;
  localparam int PROD_W = DW + 32;
  localparam logic [17:0] FADE_K = 18'(3 << FRAC_W);

  function automatic logic signed [DW-1:0] dot3(grad_t g,
                                                logic signed [16:0] rx,
                                                logic signed [16:0] ry,
                                                logic signed [16:0] rz);
    logic signed [34:0] p1;
    logic signed [34:0] p2;
    logic signed [34:0] p3;
    logic signed [34:0] acc;
    p1  = rx * g.gx;
    p2  = ry * g.gy;
    p3  = rz * g.gz;
    acc = p1 + p2 + p3;
    return DW'(acc >>> 15);
  endfunction

  state_t                   state_r;
  logic [4:0]               step_r;
  logic                     turb_r;
  logic [OCT_W-1:0]         oct_left_r;
  logic [COORD_W-1:0]       ux_r, uy_r, uz_r;
  logic [COORD_W-1:0]       tx_r, ty_r, tz_r;
  logic [31:0]              w_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [15:0]              t2_r;
  logic [16:0]              sx_r, sy_r, sz_r;
  logic [TAW-1:0]           i_r, j_r, b00_r, b10_r, b01_r, b11_r;
  logic signed [DW-1:0]     d_r [8];
  logic signed [DW-1:0]     ax_r, bx_r, c_r, dd_r, v_r, nz_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [31:0]       res_val_r;
  logic                     res_sat_r;
  logic signed [31:0]       out_val_r;
  logic                     out_sat_r;
  logic                     out_valid_r;

  logic [TAW-1:0] perm_mem [TABLE_SIZE];
  grad_t          grad_mem [TABLE_SIZE];
  logic [TAW-1:0] pa_addr, pb_addr, ga_addr, gb_addr;
  logic [TAW-1:0] pa_rd_r, pb_rd_r;
  grad_t          ga_rd_r, gb_rd_r;

  // lattice cells and fractions
  logic [TAW-1:0]      c0x, c1x, c0y, c1y, c0z, c1z;
  logic signed [16:0]  r0x, r1x, r0y, r1y, r0z, r1z;

  assign c0x = tx_r[COORD_W-1:FRAC_W];
  assign c0y = ty_r[COORD_W-1:FRAC_W];
  assign c0z = tz_r[COORD_W-1:FRAC_W];
  assign c1x = c0x + TAW'(1);
  assign c1y = c0y + TAW'(1);
  assign c1z = c0z + TAW'(1);
  assign r0x = signed'({1'b0, tx_r[FRAC_W-1:0]});
  assign r1x = signed'({1'b1, tx_r[FRAC_W-1:0]});
  assign r0y = signed'({1'b0, ty_r[FRAC_W-1:0]});
  assign r1y = signed'({1'b1, ty_r[FRAC_W-1:0]});
  assign r0z = signed'({1'b0, tz_r[FRAC_W-1:0]});
  assign r1z = signed'({1'b1, tz_r[FRAC_W-1:0]});

  // table read addresses per step
  always_comb begin
    pa_addr = '0;
    pb_addr = '0;
    ga_addr = '0;
    gb_addr = '0;
    case (step_r)
      S_PX: begin
        pa_addr = c0x;
        pb_addr = c1x;
      end
      S_PY0: begin
        pa_addr = pa_rd_r + c0y;
        pb_addr = pb_rd_r + c0y;
      end
      S_PY1: begin
        pa_addr = i_r + c1y;
        pb_addr = j_r + c1y;
      end
      S_G0: begin
        ga_addr = b00_r + c0z;
        gb_addr = b10_r + c0z;
      end
      S_G1: begin
        ga_addr = b01_r + c0z;
        gb_addr = b11_r + c0z;
      end
      S_G2: begin
        ga_addr = b00_r + c1z;
        gb_addr = b10_r + c1z;
      end
      S_G3: begin
        ga_addr = b01_r + c1z;
        gb_addr = b11_r + c1z;
      end
      default: begin
        pa_addr = '0;
      end
    endcase
  end

  // fade unit: t*t, then t2*(3-2t), one axis per two steps
  logic [15:0] fr;
  logic [31:0] fsq;
  logic [17:0] fk;
  logic [33:0] fprod;

  always_comb begin
    case (step_r)
      S_PY1, S_G0: fr = ty_r[FRAC_W-1:0];
      S_G1, S_G2:  fr = tz_r[FRAC_W-1:0];
      default:     fr = tx_r[FRAC_W-1:0];
    endcase
  end
  assign fsq   = fr * fr;
  assign fk    = FADE_K - {1'b0, fr, 1'b0};
  assign fprod = t2_r * fk;

  // dot units: unit A at x fraction, unit B at x fraction minus one
  logic signed [16:0]   dry, drz;
  logic signed [DW-1:0] dot_a, dot_b;

  assign dry   = (step_r == S_G2 || step_r == S_G4) ? r1y : r0y;
  assign drz   = (step_r == S_G3 || step_r == S_G4) ? r1z : r0z;
  assign dot_a = dot3(ga_rd_r, r0x, dry, drz);
  assign dot_b = dot3(gb_rd_r, r1x, dry, drz);

  // blend unit: a + ((s*(b-a)) >> 16)
  logic [16:0]          bs;
  logic signed [DW-1:0] ba, bb, blend_v;
  logic signed [DW:0]   bdiff;
  logic signed [DW+18:0] bprod;

  always_comb begin
    bs = sx_r;
    ba = d_r[0];
    bb = d_r[1];
    case (step_r)
      S_L1: begin
        ba = d_r[2];
        bb = d_r[3];
      end
      S_L2, S_L5: begin
        bs = sy_r;
        ba = ax_r;
        bb = bx_r;
      end
      S_L3: begin
        ba = d_r[4];
        bb = d_r[5];
      end
      S_L4: begin
        ba = d_r[6];
        bb = d_r[7];
      end
      S_L6: begin
        bs = sz_r;
        ba = c_r;
        bb = dd_r;
      end
      default: begin
        bs = sx_r;
      end
    endcase
  end
  assign bdiff   = bb - ba;
  assign bprod   = bdiff * signed'({1'b0, bs});
  assign blend_v = ba + DW'(bprod >>> 16);

  // 1.5x scale, magnitude and turbulence term
  logic signed [DW+1:0]     v3;
  logic signed [DW-1:0]     nz;
  logic [DW-1:0]            mag;
  logic [OCT_W-1:0]         n_oct;
  logic [31:0]              x_sum;
  logic signed [SUM_W:0]    fin_v;
  logic                     fin_sat;
  logic signed [31:0]       fin_val;

  assign v3    = (v_r <<< 1) + v_r;
  assign nz    = DW'(v3 >>> 1);
  assign mag   = nz_r[DW-1] ? DW'(-nz_r) : DW'(nz_r);
  assign n_oct = (cfg.octave_count > MAX_OCT) ? MAX_OCT : cfg.octave_count;
  assign x_sum = q_ent.pos_x + cfg.x_offset;

  // bias and saturation to 32 bits
  assign fin_v   = sum_r + cfg.turb_bias;
  assign fin_sat = !((&fin_v[SUM_W:31]) || !(|fin_v[SUM_W:31]));
  assign fin_val = !fin_sat ? fin_v[31:0] :
                   (fin_v[SUM_W] ? 32'sh80000000 : 32'sh7fffffff);

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  // table memories, registered reads
  always_ff @(posedge clk) begin
    if (q_pop && q_ent.kind == REQ_PERM) begin
      perm_mem[q_ent.idx] <= q_ent.pval;
    end
    if (q_pop && q_ent.kind == REQ_GRAD) begin
      grad_mem[q_ent.idx] <= q_ent.grad;
    end
    pa_rd_r <= perm_mem[pa_addr];
    pb_rd_r <= perm_mem[pb_addr];
    ga_rd_r <= grad_mem[ga_addr];
    gb_rd_r <= grad_mem[gb_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_TCALC;
      oct_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output drains; in the emit state the load below decides instead
      if (out_ch.ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid && q_ent.kind == REQ_EVAL) begin
            step_r <= S_TCALC;
            sum_r  <= '0;
            w_r    <= cfg.inv_low_freq;
            uy_r   <= q_ent.pos_y[COORD_W-1:0];
            uz_r   <= q_ent.pos_z[COORD_W-1:0];
            if (!cfg.eval_mode) begin
              turb_r     <= 1'b0;
              ux_r       <= q_ent.pos_x[COORD_W-1:0];
              oct_left_r <= OCT_W'(1);
              state_r    <= ST_RUN;
            end else begin
              turb_r     <= 1'b1;
              ux_r       <= x_sum[COORD_W-1:0];
              oct_left_r <= n_oct;
              if (n_oct == '0) begin
                res_val_r <= cfg.turb_bias;
                res_sat_r <= 1'b0;
                state_r   <= ST_EMIT;
              end else begin
                state_r <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          step_r <= step_r + 5'd1;
          case (step_r)
            S_TCALC: begin
              tx_r <= ux_r + LAT_Q;
              ty_r <= uy_r + LAT_Q;
              tz_r <= uz_r + LAT_Q;
            end
            S_PX: t2_r <= fsq[31:16];
            S_PY0: begin
              i_r  <= pa_rd_r;
              j_r  <= pb_rd_r;
              sx_r <= fprod[32:16];
            end
            S_PY1: begin
              b00_r <= pa_rd_r;
              b10_r <= pb_rd_r;
              t2_r  <= fsq[31:16];
            end
            S_G0: begin
              b01_r <= pa_rd_r;
              b11_r <= pb_rd_r;
              sy_r  <= fprod[32:16];
            end
            S_G1: begin
              d_r[0] <= dot_a;
              d_r[1] <= dot_b;
              t2_r   <= fsq[31:16];
            end
            S_G2: begin
              d_r[2] <= dot_a;
              d_r[3] <= dot_b;
              sz_r   <= fprod[32:16];
            end
            S_G3: begin
              d_r[4] <= dot_a;
              d_r[5] <= dot_b;
            end
            S_G4: begin
              d_r[6] <= dot_a;
              d_r[7] <= dot_b;
            end
            S_L0, S_L3: ax_r <= blend_v;
            S_L1, S_L4: bx_r <= blend_v;
            S_L2: c_r  <= blend_v;
            S_L5: dd_r <= blend_v;
            S_L6: v_r  <= blend_v;
            S_NZ: begin
              nz_r <= nz;
              if (!turb_r) begin
                res_val_r <= 32'(nz);
                res_sat_r <= 1'b0;
                state_r   <= ST_EMIT;
              end
            end
            S_MUL: prod_r <= mag * w_r;
            S_ACC: begin
              sum_r      <= sum_r + signed'({4'b0, prod_r[PROD_W-1:16]});
              ux_r       <= {ux_r[COORD_W-2:0], 1'b0};
              uy_r       <= {uy_r[COORD_W-2:0], 1'b0};
              uz_r       <= {uz_r[COORD_W-2:0], 1'b0};
              w_r        <= w_r >> 1;
              oct_left_r <= oct_left_r - OCT_W'(1);
              if (oct_left_r == OCT_W'(1)) begin
                step_r <= S_FIN;
              end else begin
                step_r <= S_TCALC;
              end
            end
            S_FIN: begin
              res_val_r <= fin_val;
              res_sat_r <= fin_sat;
              state_r   <= ST_EMIT;
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_val_r   <= res_val_r;
            out_sat_r   <= res_sat_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.saturated    = out_sat_r;

  `PNT3D_ASSERT_IMP(a_pop_only_idle, q_pop, state_r == ST_IDLE, "queue popped while busy")
  `PNT3D_ASSERT_NEXT(a_eval_leaves_idle, q_pop && q_ent.kind == REQ_EVAL, state_r != ST_IDLE, "evaluate transaction dropped")
  `PNT3D_ASSERT_IMP(a_run_has_octave, state_r == ST_RUN && step_r != S_FIN, oct_left_r != '0, "running with no octave left")
  `PNT3D_ASSERT_IMP(a_sat_value, out_valid_r && out_sat_r, out_val_r == 32'sh7fffffff || out_val_r == 32'sh80000000, "saturated flag without clipped value")

endmodule

FILE: sv/perlin_noise_turbulence_3d.sv
// Channel   Direction  Payload
// in_ch     sink       req_type, table_index, perm_value, grad_x/y/z, pos_x/y/z
// out_ch    source     result_value, saturated
// cfg_ch    sink       reg_index, wr_data
//
// Table loads are written in the back end when popped; the front queue keeps taking
// transactions while the back end works, until its two entries are full. Noise and
// turbulence evaluations run on the shared octave sequencer and its two-port table
// reads. Reset is synchronous, active low; tables are undefined until loaded. The
// output register lets one result wait for the sink.
module perlin_noise_turbulence_3d (
  input  logic        clk,
  input  logic        rst_n,
  pnt3d_in_if.sink    in_ch,
  pnt3d_out_if.source out_ch,
  pnt3d_cfg_if.sink   cfg_ch
);
  import pnt3d_pkg::*;

  cfg_t    cfg_r;
  q_item_t q_ent;
  logic    q_valid;
  logic    q_pop;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_MODE:   cfg_r.eval_mode    <= cfg_ch.wr_data[0];
        CFG_OCT:    cfg_r.octave_count <= cfg_ch.wr_data[OCT_W-1:0];
        CFG_INV_LF: cfg_r.inv_low_freq <= cfg_ch.wr_data;
        CFG_X_OFF:  cfg_r.x_offset     <= cfg_ch.wr_data;
        CFG_BIAS:   cfg_r.turb_bias    <= cfg_ch.wr_data;
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  pnt3d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ent   (q_ent),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  pnt3d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_ent   (q_ent),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
